// ----- design/systick_timer_with_reload_clamp_top_assert.svh -----
// Assertion macros shared by the checker of the system timer.
`ifndef SYSTICK_TIMER_WITH_RELOAD_CLAMP_TOP_ASSERT_SVH
`define SYSTICK_TIMER_WITH_RELOAD_CLAMP_TOP_ASSERT_SVH

// Checked outside reset only.
`define STK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define STK_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/stk_pkg.sv -----
package stk_pkg;

    localparam int unsigned CNT_W    = 24;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned CLAMP_PERIODS = 3;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [1:0] REG_CSR     = 2'd0;
    localparam logic [1:0] REG_RELOAD  = 2'd1;
    localparam logic [1:0] REG_CURRENT = 2'd2;
    localparam logic [1:0] REG_CALIB   = 2'd3;

    localparam logic CFG_OVR_ENABLE = 1'b0;
    localparam logic CFG_OVR_RELOAD = 1'b1;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [1:0]        reg_index;
        logic [DATA_W-1:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_pend;
    } t_out_item;

    typedef struct packed {
        logic             we;
        logic             index;
        logic [CNT_W-1:0] wdata;
    } t_cfg_wr;

endpackage

// ----- design/systick_timer_with_reload_clamp_top.sv -----
// System timer with reload clamp: one register read, write or tick per transfer.
// The result passes through the input register, then the result register, before it is offered;
// throughput is one item per cycle while the result is taken (a stalled result holds the input
// register), set by the single-pass update.
// Reset clears the control bits, count flag, reload, count and both override registers;
// the block is ready for a transfer in the first cycle after reset.
module systick_timer_with_reload_clamp_top #(
    parameter int unsigned TICKS_TEN_MS = 10000
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  stk_pkg::t_in_item     i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output stk_pkg::t_out_item    o_out,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [stk_pkg::CNT_W-1:0] i_cfg_wdata
);
    import stk_pkg::*;

    logic      q_valid;
    t_in_item  q_item;
    logic      out_can_load;
    logic      fire;
    t_out_item result;
    t_cfg_wr   cfg_wr;

    assign fire          = q_valid && out_can_load;
    assign cfg_wr.we     = i_cfg_we;
    assign cfg_wr.index  = i_cfg_index;
    assign cfg_wr.wdata  = i_cfg_wdata;

    stk_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (i_in),
        .i_advance (fire),
        .o_valid   (q_valid),
        .o_item    (q_item)
    );

    stk_core #(
        .TICKS_TEN_MS (TICKS_TEN_MS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_wr (cfg_wr),
        .i_fire   (fire),
        .i_item   (q_item),
        .o_result (result)
    );

    stk_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_item     (result),
        .o_can_load (out_can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_item     (o_out)
    );

endmodule

// ----- design/stk_in_reg.sv -----
module stk_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  stk_pkg::t_in_item  i_item,
    input  logic               i_advance,
    output logic               o_valid,
    output stk_pkg::t_in_item  o_item
);
    import stk_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- design/stk_core.sv -----
module stk_core #(
    parameter int unsigned TICKS_TEN_MS = 10000
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stk_pkg::t_cfg_wr   i_cfg_wr,
    input  logic               i_fire,
    input  stk_pkg::t_in_item  i_item,
    output stk_pkg::t_out_item o_result
);
    import stk_pkg::*;

    localparam logic [DATA_W-1:0] RELOAD_LO = DATA_W'(TICKS_TEN_MS);
    localparam logic [DATA_W-1:0] RELOAD_HI = DATA_W'(CLAMP_PERIODS * TICKS_TEN_MS);

    logic             r_ovr_en;
    logic [CNT_W-1:0] r_ovr_reload;

    logic             r_en;
    logic             r_tickint;
    logic             r_clksrc;
    logic             r_cflag;
    logic [CNT_W-1:0] r_reload;
    logic [CNT_W-1:0] r_count;

    logic             n_en;
    logic             n_tickint;
    logic             n_clksrc;
    logic             n_cflag;
    logic [CNT_W-1:0] n_reload;
    logic [CNT_W-1:0] n_count;

    logic             wr_en;
    logic             wr_cs;

    always_comb begin
        n_en      = r_en;
        n_tickint = r_tickint;
        n_clksrc  = r_clksrc;
        n_cflag   = r_cflag;
        n_reload  = r_reload;
        n_count   = r_count;
        o_result  = '0;
        wr_en     = i_item.write_data[0];
        wr_cs     = i_item.write_data[2];
        unique case (i_item.cmd)
            CMD_READ: begin
                unique case (i_item.reg_index)
                    REG_CSR: begin
                        o_result.read_data = {15'd0, r_cflag, 13'd0, r_clksrc, r_tickint, r_en};
                        n_cflag = 1'b1;
                    end
                    REG_RELOAD: begin
                        o_result.read_data = DATA_W'(r_reload);
                    end
                    REG_CURRENT: begin
                        o_result.read_data = DATA_W'(r_count);
                    end
                    REG_CALIB: begin
                        o_result.read_data = RELOAD_LO;
                    end
                endcase
            end
            CMD_WRITE: begin
                unique case (i_item.reg_index)
                    REG_CSR: begin
                        if (wr_en != r_en) begin
                            if (wr_en) begin
                                n_count = r_reload;
                            end
                        end else if (wr_cs != r_clksrc) begin
                            n_count = r_reload;
                        end
                        n_en      = wr_en;
                        n_tickint = i_item.write_data[1];
                        n_clksrc  = wr_cs;
                    end
                    REG_RELOAD: begin
                        if (r_ovr_en) begin
                            n_reload = r_ovr_reload;
                        end else if (i_item.write_data < RELOAD_LO) begin
                            n_reload = RELOAD_LO[CNT_W-1:0];
                        end else if (i_item.write_data > RELOAD_HI) begin
                            n_reload = RELOAD_HI[CNT_W-1:0];
                        end else begin
                            n_reload = i_item.write_data[CNT_W-1:0];
                        end
                    end
                    REG_CURRENT: begin
                        n_cflag = 1'b0;
                        n_count = r_reload;
                    end
                    REG_CALIB: begin
                    end
                endcase
            end
            CMD_TICK: begin
                if (r_en) begin
                    if (r_count == '0) begin
                        n_count = r_reload;
                    end else if (r_count == CNT_W'(1)) begin
                        n_cflag            = 1'b1;
                        o_result.irq_pend  = r_tickint;
                        n_count            = r_reload;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovr_en     <= 1'b0;
            r_ovr_reload <= '0;
        end else if (i_cfg_wr.we) begin
            unique case (i_cfg_wr.index)
                CFG_OVR_ENABLE: r_ovr_en     <= i_cfg_wr.wdata[0];
                CFG_OVR_RELOAD: r_ovr_reload <= i_cfg_wr.wdata;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en      <= 1'b0;
            r_tickint <= 1'b0;
            r_clksrc  <= 1'b0;
            r_cflag   <= 1'b0;
            r_reload  <= '0;
            r_count   <= '0;
        end else if (i_fire) begin
            r_en      <= n_en;
            r_tickint <= n_tickint;
            r_clksrc  <= n_clksrc;
            r_cflag   <= n_cflag;
            r_reload  <= n_reload;
            r_count   <= n_count;
        end
    end

endmodule

// ----- design/stk_out_reg.sv -----
module stk_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  stk_pkg::t_out_item i_item,
    output logic               o_can_load,
    output logic               o_valid,
    input  logic               i_ready,
    output stk_pkg::t_out_item o_item
);
    import stk_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- design/stk_checker.sv -----
`include "systick_timer_with_reload_clamp_top_assert.svh"

module stk_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input stk_pkg::t_out_item o_out
);
    import stk_pkg::*;

    logic [1:0] r_inflight;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 2'(in_xfer) - 2'(out_xfer);
        end
    end

    `STK_ASSERT(a_out_valid_held, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "result withdrawn before transfer")
    `STK_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_out), "stalled result changed")
    `STK_ASSERT(a_no_orphan, i_clk, i_rst_n, o_out_valid |-> r_inflight != 2'd0 && r_inflight != 2'd3, "result without a pending input")
    `STK_ASSERT(a_irq_excl, i_clk, i_rst_n, o_out_valid && o_out.irq_pend |-> o_out.read_data == '0, "interrupt pend on a read result")
    `STK_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid, "result offered after reset")

endmodule

bind systick_timer_with_reload_clamp_top stk_checker u_stk_checker (.*);
